// ===== src/euler_vector_rotation_defines.svh =====
// ----------------------------------------------------------------------------
// Euler vector rotation assertion macros
// Shared property wrappers for the block's checker.
// ----------------------------------------------------------------------------
`ifndef EULER_VECTOR_ROTATION_DEFINES_SVH
`define EULER_VECTOR_ROTATION_DEFINES_SVH

// check outside reset
`define EUL_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check at every edge, reset included
`define EUL_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== src/eul_pkg.sv =====
// ----------------------------------------------------------------------------
// Euler vector rotation package
// Shared constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package eul_pkg;

   localparam int PHASE_W = 32;
   localparam int CORDIC_W = 34;
   localparam int MAX_STEPS = 32;
   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

   typedef enum logic [1:0] {
      OP_ZYX_FWD = 2'd0,
      OP_XYZ_FWD = 2'd1,
      OP_XYZ_NEG = 2'd2,
      OP_ZYX_NEG = 2'd3
   } opcode_type;

   function automatic logic [PHASE_W-1:0] atan_entry(input logic [4:0] idx);
      logic [PHASE_W-1:0] v;
      unique case (idx)
         5'd0: v = 32'd536870912;
         5'd1: v = 32'd316933406;
         5'd2: v = 32'd167458907;
         5'd3: v = 32'd85004756;
         5'd4: v = 32'd42667331;
         5'd5: v = 32'd21354465;
         5'd6: v = 32'd10679838;
         5'd7: v = 32'd5340245;
         5'd8: v = 32'd2670163;
         5'd9: v = 32'd1335087;
         5'd10: v = 32'd667544;
         5'd11: v = 32'd333772;
         5'd12: v = 32'd166886;
         5'd13: v = 32'd83443;
         5'd14: v = 32'd41722;
         5'd15: v = 32'd20861;
         5'd16: v = 32'd10430;
         5'd17: v = 32'd5215;
         5'd18: v = 32'd2608;
         5'd19: v = 32'd1304;
         5'd20: v = 32'd652;
         5'd21: v = 32'd326;
         5'd22: v = 32'd163;
         5'd23: v = 32'd81;
         5'd24: v = 32'd41;
         5'd25: v = 32'd20;
         5'd26: v = 32'd10;
         5'd27: v = 32'd5;
         5'd28: v = 32'd3;
         5'd29: v = 32'd1;
         5'd30: v = 32'd1;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

endpackage

// ===== src/eul_front.sv =====
// ----------------------------------------------------------------------------
// Euler vector rotation front end
// Accepts a transaction, decodes the opcode and folds each angle into a phase.
// ----------------------------------------------------------------------------
module eul_front #(
   parameter int COORD_WIDTH = 32,
   parameter int ANGLE_WIDTH = 16,
   parameter int IN_W = 152,
   parameter int QW = 4 + 3 * eul_pkg::PHASE_W + 3 * COORD_WIDTH
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  logic [IN_W-1:0] req_tdata,
   input  logic [1:0]      req_tuser,
   output logic            f_vld,
   output logic [QW-1:0]   f_data,
   input  logic            f_rdy
);

   localparam int PW = eul_pkg::PHASE_W;
   localparam int CW = COORD_WIDTH;
   localparam int AW = ANGLE_WIDTH;

   logic          vld_ff;
   logic [QW-1:0] data_ff;
   logic [QW-1:0] data_in;
   logic          neg;
   logic          x_first;
   logic          take;

   function automatic logic [PW:0] fold(input logic [AW-1:0] ang, input logic negate);
      logic [PW-1:0] p;
      logic          flip;
      p = PW'(ang) << (PW - AW);
      if (negate) begin
         p = '0 - p;
      end
      flip = p[PW-1] ^ p[PW-2];
      p[PW-1] = p[PW-1] ^ flip;
      return {flip, p};
   endfunction

   assign neg = (req_tuser == eul_pkg::OP_XYZ_NEG) || (req_tuser == eul_pkg::OP_ZYX_NEG);
   assign x_first = (req_tuser == eul_pkg::OP_ZYX_FWD) || (req_tuser == eul_pkg::OP_ZYX_NEG);
   assign req_tready = !vld_ff || f_rdy;
   assign take = req_tvalid && req_tready;

   always_comb begin
      logic [PW:0] fx;
      logic [PW:0] fy;
      logic [PW:0] fz;
      fx = fold(req_tdata[3*CW +: AW], neg);
      fy = fold(req_tdata[3*CW+AW +: AW], neg);
      fz = fold(req_tdata[3*CW+2*AW +: AW], neg);
      data_in = {req_tdata[3*CW-1:0], fz[PW-1:0], fy[PW-1:0], fx[PW-1:0],
                 fz[PW], fy[PW], fx[PW], x_first};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (req_tready) begin
         vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= data_in;
      end
   end

   assign f_vld = vld_ff;
   assign f_data = data_ff;

endmodule

// ===== src/eul_queue.sv =====
// ----------------------------------------------------------------------------
// Euler vector rotation queue
// Short queue that decouples the front end from the rotation pipeline.
// ----------------------------------------------------------------------------
module eul_queue #(
   parameter int QW = 200
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push_vld,
   output logic          push_rdy,
   input  logic [QW-1:0] push_data,
   output logic          pop_vld,
   input  logic          pop_rdy,
   output logic [QW-1:0] pop_data
);

   localparam int DEPTH = 4;
   localparam int AW = $clog2(DEPTH);

   logic [QW-1:0] mem_ff [0:DEPTH-1];
   logic [AW-1:0] wr_ff;
   logic [AW-1:0] rd_ff;
   logic [AW:0]   cnt_ff;
   logic          push;
   logic          pop;

   assign push_rdy = (cnt_ff != (AW+1)'(DEPTH));
   assign pop_vld = (cnt_ff != '0);
   assign push = push_vld && push_rdy;
   assign pop = pop_vld && pop_rdy;
   assign pop_data = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

endmodule

// ===== src/eul_back.sv =====
// ----------------------------------------------------------------------------
// Euler vector rotation back end
// CORDIC sine and cosine, three planar rotations and output saturation.
// ----------------------------------------------------------------------------
module eul_back #(
   parameter int COORD_WIDTH = 32,
   parameter int CORDIC_STEPS = 16,
   parameter int QW = 4 + 3 * eul_pkg::PHASE_W + 3 * COORD_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_vld,
   output logic                   q_rdy,
   input  logic [QW-1:0]          q_data,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [3*COORD_WIDTH-1:0] rsp_data,
   output logic                   rsp_ov
);

   localparam int CW = COORD_WIDTH;
   localparam int NS = (CORDIC_STEPS < eul_pkg::MAX_STEPS) ? CORDIC_STEPS
                                                          : eul_pkg::MAX_STEPS;
   localparam int IW = (COORD_WIDTH + 2 > 64) ? 64 : COORD_WIDTH + 2;
   localparam int KW = eul_pkg::CORDIC_W;
   localparam int PH = eul_pkg::PHASE_W;
   localparam int ZW = PH + 1;
   localparam int PW = IW + KW;
   localparam int SW = PW + 1;
   localparam int RW = SW - 30;
   localparam logic signed [SW-1:0] HALF = SW'(32'sd536870912);

   logic                 adv;
   logic                 cv_ff  [0:NS];
   logic                 cxf_ff [0:NS];
   logic                 cfl_ff [0:NS][0:2];
   logic signed [KW-1:0] cx_ff  [0:NS][0:2];
   logic signed [KW-1:0] cy_ff  [0:NS][0:2];
   logic signed [ZW-1:0] cz_ff  [0:NS][0:2];
   logic signed [IW-1:0] cvec_ff [0:NS][0:2];

   logic                 rvld_ff [0:3];
   logic                 rxf_ff  [0:3];
   logic                 rov_ff  [0:3];
   logic signed [KW-1:0] rc_ff   [0:3][0:2];
   logic signed [KW-1:0] rs_ff   [0:3][0:2];
   logic signed [IW-1:0] rv_ff   [0:3][0:2];

   logic                 mvld_ff [0:2];
   logic                 mxf_ff  [0:2];
   logic                 mov_ff  [0:2];
   logic signed [KW-1:0] mc_ff   [0:2][0:2];
   logic signed [KW-1:0] ms_ff   [0:2][0:2];
   logic signed [IW-1:0] mv_ff   [0:2][0:2];
   logic signed [PW-1:0] mp_ff   [0:2][0:3];

   logic                 ovld_ff;
   logic [3*CW-1:0]      odata_ff;
   logic                 oov_ff;

   function automatic logic signed [IW-1:0] sat_val(input logic signed [RW-1:0] w);
      logic [RW-IW:0] hi;
      hi = w[RW-1:IW-1];
      if ((&hi) || !(|hi)) begin
         return w[IW-1:0];
      end
      return w[RW-1] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
   endfunction

   function automatic logic sat_ov(input logic signed [RW-1:0] w);
      logic [RW-IW:0] hi;
      hi = w[RW-1:IW-1];
      return !((&hi) || !(|hi));
   endfunction

   function automatic logic [CW:0] sat_out(input logic signed [IW-1:0] w);
      logic [IW-CW:0] hi;
      hi = w[IW-1:CW-1];
      if ((&hi) || !(|hi)) begin
         return {1'b0, w[CW-1:0]};
      end
      return w[IW-1] ? {1'b1, 1'b1, {(CW-1){1'b0}}} : {1'b1, 1'b0, {(CW-1){1'b1}}};
   endfunction

   assign adv = !ovld_ff || rsp_tready;
   assign q_rdy = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= NS; i++) begin
            cv_ff[i] <= 1'b0;
         end
         for (int k = 0; k <= 3; k++) begin
            rvld_ff[k] <= 1'b0;
         end
         for (int k = 0; k < 3; k++) begin
            mvld_ff[k] <= 1'b0;
         end
         ovld_ff <= 1'b0;
      end else if (adv) begin
         cv_ff[0] <= q_vld;
         for (int i = 0; i < NS; i++) begin
            cv_ff[i+1] <= cv_ff[i];
         end
         rvld_ff[0] <= cv_ff[NS];
         for (int k = 0; k < 3; k++) begin
            mvld_ff[k] <= rvld_ff[k];
            rvld_ff[k+1] <= mvld_ff[k];
         end
         ovld_ff <= rvld_ff[3];
      end
   end

   always_ff @(posedge clock) begin
      logic signed [KW-1:0] dx;
      logic signed [KW-1:0] dy;
      logic signed [ZW-1:0] at;
      logic signed [IW-1:0] p;
      logic signed [IW-1:0] q;
      logic signed [KW-1:0] c;
      logic signed [KW-1:0] s;
      logic signed [SW-1:0] sp;
      logic signed [SW-1:0] sq;
      logic signed [RW-1:0] wp;
      logic signed [RW-1:0] wq;
      logic [CW:0]          fx;
      logic [CW:0]          fy;
      logic [CW:0]          fz;
      int                   pidx;
      int                   qidx;
      if (adv) begin
         // load a transaction from the queue
         cxf_ff[0] <= q_data[0];
         for (int a = 0; a < 3; a++) begin
            cfl_ff[0][a] <= q_data[1+a];
            cx_ff[0][a] <= eul_pkg::CORDIC_GAIN;
            cy_ff[0][a] <= '0;
            cz_ff[0][a] <= ZW'(signed'(q_data[4+PH*a +: PH]));
            cvec_ff[0][a] <= IW'(signed'(q_data[4+3*PH+CW*a +: CW]));
         end
         // CORDIC steps
         for (int i = 0; i < NS; i++) begin
            cxf_ff[i+1] <= cxf_ff[i];
            for (int a = 0; a < 3; a++) begin
               dx = cy_ff[i][a] >>> i;
               dy = cx_ff[i][a] >>> i;
               at = ZW'(eul_pkg::atan_entry(5'(i)));
               cfl_ff[i+1][a] <= cfl_ff[i][a];
               cvec_ff[i+1][a] <= cvec_ff[i][a];
               if (!cz_ff[i][a][ZW-1]) begin
                  cx_ff[i+1][a] <= cx_ff[i][a] - dx;
                  cy_ff[i+1][a] <= cy_ff[i][a] + dy;
                  cz_ff[i+1][a] <= cz_ff[i][a] - at;
               end else begin
                  cx_ff[i+1][a] <= cx_ff[i][a] + dx;
                  cy_ff[i+1][a] <= cy_ff[i][a] - dy;
                  cz_ff[i+1][a] <= cz_ff[i][a] + at;
               end
            end
         end
         // quadrant fix-up
         rxf_ff[0] <= cxf_ff[NS];
         rov_ff[0] <= 1'b0;
         for (int a = 0; a < 3; a++) begin
            rc_ff[0][a] <= cfl_ff[NS][a] ? -cx_ff[NS][a] : cx_ff[NS][a];
            rs_ff[0][a] <= cfl_ff[NS][a] ? -cy_ff[NS][a] : cy_ff[NS][a];
            rv_ff[0][a] <= cvec_ff[NS][a];
         end
         // planar rotations, multiply then round and clamp
         for (int k = 0; k < 3; k++) begin
            if (rxf_ff[k]) begin
               p = rv_ff[k][(k+1)%3];
               q = rv_ff[k][(k+2)%3];
               c = rc_ff[k][k];
               s = rs_ff[k][k];
            end else begin
               p = rv_ff[k][(3-k)%3];
               q = rv_ff[k][(4-k)%3];
               c = rc_ff[k][2-k];
               s = rs_ff[k][2-k];
            end
            mp_ff[k][0] <= PW'(p) * PW'(c);
            mp_ff[k][1] <= PW'(q) * PW'(s);
            mp_ff[k][2] <= PW'(p) * PW'(s);
            mp_ff[k][3] <= PW'(q) * PW'(c);
            mxf_ff[k] <= rxf_ff[k];
            mov_ff[k] <= rov_ff[k];
            for (int a = 0; a < 3; a++) begin
               mc_ff[k][a] <= rc_ff[k][a];
               ms_ff[k][a] <= rs_ff[k][a];
               mv_ff[k][a] <= rv_ff[k][a];
            end

            sp = SW'(mp_ff[k][0]) - SW'(mp_ff[k][1]) + HALF;
            sq = SW'(mp_ff[k][2]) + SW'(mp_ff[k][3]) + HALF;
            wp = RW'(sp >>> 30);
            wq = RW'(sq >>> 30);
            if (mxf_ff[k]) begin
               pidx = (k+1)%3;
               qidx = (k+2)%3;
            end else begin
               pidx = (3-k)%3;
               qidx = (4-k)%3;
            end
            rxf_ff[k+1] <= mxf_ff[k];
            rov_ff[k+1] <= mov_ff[k] | sat_ov(wp) | sat_ov(wq);
            for (int a = 0; a < 3; a++) begin
               rc_ff[k+1][a] <= mc_ff[k][a];
               rs_ff[k+1][a] <= ms_ff[k][a];
               if (a == pidx) begin
                  rv_ff[k+1][a] <= sat_val(wp);
               end else if (a == qidx) begin
                  rv_ff[k+1][a] <= sat_val(wq);
               end else begin
                  rv_ff[k+1][a] <= mv_ff[k][a];
               end
            end
         end
         // final clamp
         fx = sat_out(rv_ff[3][0]);
         fy = sat_out(rv_ff[3][1]);
         fz = sat_out(rv_ff[3][2]);
         odata_ff <= {fz[CW-1:0], fy[CW-1:0], fx[CW-1:0]};
         oov_ff <= rov_ff[3] | fx[CW] | fy[CW] | fz[CW];
      end
   end

   assign rsp_tvalid = ovld_ff;
   assign rsp_data = odata_ff;
   assign rsp_ov = oov_ff;

endmodule

// ===== src/euler_vector_rotation.sv =====
// ----------------------------------------------------------------------------
// Euler vector rotation
// Rotates a fixed-point 3D vector by X, Y and Z angles via CORDIC.
// ----------------------------------------------------------------------------
//  channel   direction  tdata                               tuser
//  req_      in         x_in, y_in, z_in, angle_x/y/z       opcode
//  rsp_      out        x_out, y_out, z_out                 overflow
//
//  One transaction per cycle sustained; the CORDIC and rotation pipeline
//  advances every cycle the output register is free.
//  Latency is set by the CORDIC stage count, CORDIC_STEPS capped at MAX_STEPS.
//  Reset is synchronous and empties all stages and the queue.
//  A stalled rsp_ halts the pipeline; the queue absorbs up to four more.
// ----------------------------------------------------------------------------
module euler_vector_rotation #(
   parameter int COORD_WIDTH = 32,
   parameter int ANGLE_WIDTH = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // x_in, y_in, z_in, angle_x, angle_y, angle_z, zero fill
   input  logic [((3*COORD_WIDTH+3*ANGLE_WIDTH+7)/8)*8-1:0] req_tdata,
   // opcode
   input  logic [1:0] req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // x_out, y_out, z_out, zero fill
   output logic [((3*COORD_WIDTH+7)/8)*8-1:0] rsp_tdata,
   // overflow
   output logic rsp_tuser
);

   localparam int IN_W = ((3*COORD_WIDTH+3*ANGLE_WIDTH+7)/8)*8;
   localparam int OUT_W = ((3*COORD_WIDTH+7)/8)*8;
   localparam int QW = 4 + 3 * eul_pkg::PHASE_W + 3 * COORD_WIDTH;

   logic                     f_vld;
   logic                     f_rdy;
   logic [QW-1:0]            f_data;
   logic                     q_vld;
   logic                     q_rdy;
   logic [QW-1:0]            q_data;
   logic [3*COORD_WIDTH-1:0] rsp_data;

   eul_front #(
      .COORD_WIDTH(COORD_WIDTH),
      .ANGLE_WIDTH(ANGLE_WIDTH),
      .IN_W(IN_W),
      .QW(QW)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .f_vld(f_vld),
      .f_data(f_data),
      .f_rdy(f_rdy)
   );

   eul_queue #(
      .QW(QW)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push_vld(f_vld),
      .push_rdy(f_rdy),
      .push_data(f_data),
      .pop_vld(q_vld),
      .pop_rdy(q_rdy),
      .pop_data(q_data)
   );

   eul_back #(
      .COORD_WIDTH(COORD_WIDTH),
      .CORDIC_STEPS(CORDIC_STEPS),
      .QW(QW)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .q_vld(q_vld),
      .q_rdy(q_rdy),
      .q_data(q_data),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_data(rsp_data),
      .rsp_ov(rsp_tuser)
   );

   assign rsp_tdata = OUT_W'(rsp_data);

endmodule

// ===== src/eul_checker.sv =====
// ----------------------------------------------------------------------------
// Euler vector rotation checker
// Port-level checks on the response channel and reset behavior.
// ----------------------------------------------------------------------------
`include "euler_vector_rotation_defines.svh"

module eul_checker #(
   parameter int OUT_W = 96
) (
   input logic             clock,
   input logic             reset,
   input logic             req_tready,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [OUT_W-1:0] rsp_tdata,
   input logic             rsp_tuser
);

   `EUL_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "rsp_tvalid dropped")
   `EUL_ASSERT(a_rsp_stable, rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser), "rsp payload changed")
   `EUL_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_tvalid && req_tready, "pipeline not empty after reset")

endmodule

bind euler_vector_rotation eul_checker #(
   .OUT_W(((3*COORD_WIDTH+7)/8)*8)
) u_eul_checker (
   .clock(clock),
   .reset(reset),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata),
   .rsp_tuser(rsp_tuser)
);

// ===== tb/tb_euler_vector_rotation.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Euler vector rotation testbench
// Streams vectors, angles and opcodes through the rotator and compares every
// rotated vector and overflow flag against a behavioral CORDIC rotation model.
// ----------------------------------------------------------------------------
module tb_euler_vector_rotation;

   localparam int CW = 32;
   localparam int AW = 16;
   localparam int STEPS = 16;
   localparam int REQ_W = ((3*CW+3*AW+7)/8)*8;
   localparam int RSP_W = ((3*CW+7)/8)*8;
   localparam int LATENCY = STEPS + 10;
   localparam int IW = 34;
   localparam int WATCHDOG = 20000;

   typedef struct {
      logic signed [31:0] x, y, z;
      logic overflow;
   } vec_result_type;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [RSP_W-1:0] rsp_tdata;
   logic rsp_tuser;

   vec_result_type rotated_q[$];
   int errors = 0;
   int idle_cycles = 0;
   bit hold_rsp = 0;
   bit stall_enable = 1;

   euler_vector_rotation #(.COORD_WIDTH(CW), .ANGLE_WIDTH(AW), .CORDIC_STEPS(STEPS)) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   always #5 clock = ~clock;

   function automatic int rand_gap();
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
      if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
      return 0;
   endfunction

   function automatic void cordic_sincos(input logic [AW-1:0] ang, input bit neg,
                                         output longint c, output longint s);
      logic [31:0] p;
      bit flip;
      longint x, y, z, dx, dy;
      p = {ang, {(32-AW){1'b0}}};
      if (neg) p = -p;
      flip = (p[31:30] == 2'd1) || (p[31:30] == 2'd2);
      if (flip) p = p + 32'h8000_0000;
      z = longint'($signed(p));
      x = 652032874;
      y = 0;
      for (int i = 0; i < STEPS && i < 32; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(eul_pkg::atan_entry(i[4:0]));
         end else begin
            x += dx; y -= dy; z += longint'(eul_pkg::atan_entry(i[4:0]));
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   function automatic longint clamp(input logic signed [127:0] v, input int w, inout bit ov);
      logic signed [127:0] hi, lo;
      hi = (128'sd1 <<< (w - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin ov = 1; return longint'(hi); end
      if (v < lo) begin ov = 1; return longint'(lo); end
      return longint'(v);
   endfunction

   function automatic void plane_turn(inout longint p, inout longint q,
                                      input longint c, input longint s, inout bit ov);
      logic signed [127:0] np, nq;
      np = (128'(p) * 128'(c) - 128'(q) * 128'(s) + (128'sd1 <<< 29)) >>> 30;
      nq = (128'(p) * 128'(s) + 128'(q) * 128'(c) + (128'sd1 <<< 29)) >>> 30;
      p = clamp(np, IW, ov);
      q = clamp(nq, IW, ov);
   endfunction

   function automatic vec_result_type rotate_vector(input eul_pkg::opcode_type op,
         input logic signed [31:0] xi, yi, zi, input logic [AW-1:0] ax, ay, az);
      vec_result_type r;
      bit ov, neg, x_first;
      longint x, y, z, cx, sx, cy, sy, cz, sz;
      ov = 0;
      neg = (op == eul_pkg::OP_XYZ_NEG) || (op == eul_pkg::OP_ZYX_NEG);
      x_first = (op == eul_pkg::OP_ZYX_FWD) || (op == eul_pkg::OP_ZYX_NEG);
      x = xi; y = yi; z = zi;
      cordic_sincos(ax, neg, cx, sx);
      cordic_sincos(ay, neg, cy, sy);
      cordic_sincos(az, neg, cz, sz);
      if (x_first) begin
         plane_turn(y, z, cx, sx, ov);
         plane_turn(z, x, cy, sy, ov);
         plane_turn(x, y, cz, sz, ov);
      end else begin
         plane_turn(x, y, cz, sz, ov);
         plane_turn(z, x, cy, sy, ov);
         plane_turn(y, z, cx, sx, ov);
      end
      r.x = 32'(clamp(128'(x), CW, ov));
      r.y = 32'(clamp(128'(y), CW, ov));
      r.z = 32'(clamp(128'(z), CW, ov));
      r.overflow = ov;
      return r;
   endfunction

   task automatic send_vector(input eul_pkg::opcode_type op, input logic [31:0] xi, yi, zi,
                              input logic [AW-1:0] ax, ay, az);
      int gap;
      gap = rand_gap();
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {az, ay, ax, zi, yi, xi};
      req_tuser <= op;
      do @(posedge clock); while (!req_tready);
      rotated_q.push_back(rotate_vector(op, xi, yi, zi, ax, ay, az));
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 4))
         0: return $urandom_range(0, 255) << 16;
         1: return -($urandom_range(0, 255) << 16);
         2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [AW-1:0] rand_angle();
      case ($urandom_range(0, 5))
         0: return {2'($urandom_range(0, 3)), 14'd0};
         1: return 16'h8000;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic test_directed();
      logic [31:0] coords[4] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'h0};
      for (int op = 0; op < 4; op++) begin
         send_vector(eul_pkg::opcode_type'(op), 32'h0001_0000, 32'h0002_0000,
                     32'hFFFD_0000, 16'h2000, 16'h1000, 16'hC000);
         send_vector(eul_pkg::opcode_type'(op), coords[op], coords[(op+1)%4],
                     coords[(op+2)%4], 16'h8000, 16'h7FFF, 16'h4000);
         send_vector(eul_pkg::opcode_type'(op), 32'h8000_0000, 32'h8000_0000,
                     32'h8000_0000, 16'h2000, 16'h2000, 16'h2000);
         send_vector(eul_pkg::opcode_type'(op), 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     32'h7FFF_FFFF, 16'hE000, 16'h6000, 16'hA000);
      end
      send_vector(eul_pkg::OP_ZYX_FWD, 32'hFFFF_FFFF, 32'h0, 32'h1, 16'h0, 16'h0, 16'h0);
      send_vector(eul_pkg::OP_XYZ_NEG, 32'h1234_5678, 32'h8765_4321, 32'h0, 16'h8000,
                  16'h8000, 16'h8000);
   endtask

   task automatic test_backpressure();
      hold_rsp = 1;
      fork
         for (int i = 0; i < 40; i++)
            send_vector(eul_pkg::opcode_type'($urandom_range(0, 3)), rand_coord(),
                        rand_coord(), rand_coord(), rand_angle(), rand_angle(),
                        rand_angle());
         begin
            repeat (60) @(posedge clock);
            hold_rsp = 0;
         end
      join
   endtask

   task automatic test_random();
      for (int i = 0; i < 880; i++) begin
         stall_enable = (i / 200) % 2 == 0;
         send_vector(eul_pkg::opcode_type'($urandom_range(0, 3)), rand_coord(),
                     rand_coord(), rand_coord(), rand_angle(), rand_angle(),
                     rand_angle());
      end
   endtask

   always @(posedge clock) begin
      if (reset || hold_rsp) rsp_tready <= 0;
      else rsp_tready <= !stall_enable || ($urandom_range(0, 3) != 0);
   end

   always @(posedge clock) begin
      vec_result_type exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (rotated_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected transaction %h / %b", $time, rsp_tdata, rsp_tuser);
         end else begin
            exp_r = rotated_q.pop_front();
            if (rsp_tdata[31:0] !== exp_r.x || rsp_tdata[63:32] !== exp_r.y ||
                rsp_tdata[95:64] !== exp_r.z || rsp_tuser !== exp_r.overflow) begin
               errors++;
               $display("%0t: expected %h %h %h ov=%b, actual %h %h %h ov=%b", $time,
                        exp_r.x, exp_r.y, exp_r.z, exp_r.overflow, rsp_tdata[31:0],
                        rsp_tdata[63:32], rsp_tdata[95:64], rsp_tuser);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG) begin
         $display("euler_vector_rotation regression: fail");
         $finish;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_random();
      req_tvalid <= 0;
      while (rotated_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (errors == 0) begin
         $display("euler_vector_rotation regression: pass");
      end else begin
         $display("euler_vector_rotation regression: fail");
      end
      $finish;
   end
endmodule

// ===== files.f =====
+incdir+src
src/eul_pkg.sv
src/eul_front.sv
src/eul_queue.sv
src/eul_back.sv
src/euler_vector_rotation.sv
src/eul_checker.sv
tb/tb_euler_vector_rotation.sv
